@@ rtl/lgrs_pkg.sv @@
// Shared constants and types for the Life generation row stepper.
`timescale 1ns / 1ps
`default_nettype none
package lgrs_pkg;

    localparam int ROW_WIDTH_DEF = 64;
    localparam int MAX_ROWS_DEF  = 1024;

    localparam int COLS_W   = 7;
    localparam int ROWNUM_W = 10;

    localparam logic [COLS_W-1:0] GRID_COLUMNS_RST = 7'd48;

    // Per-cycle control that every cell of the row sees.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/lgrs_ifs.sv @@
// Channel interfaces: incoming grid rows and outgoing next-generation rows.
`timescale 1ns / 1ps
`default_nettype none
interface lgrs_row_if #(
    parameter int ROW_WIDTH = lgrs_pkg::ROW_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic [ROW_WIDTH-1:0] row_cells;
    logic                 last_row;

    modport source (output valid, output row_cells, output last_row, input ready);
    modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface

interface lgrs_res_if #(
    parameter int ROW_WIDTH = lgrs_pkg::ROW_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [ROW_WIDTH-1:0]          next_row_cells;
    logic [lgrs_pkg::ROWNUM_W-1:0] row_number;
    logic                          frame_done;

    modport source (output valid, output next_row_cells, output row_number,
                    output frame_done, input ready);
    modport sink   (input valid, input next_row_cells, input row_number,
                    input frame_done, output ready);
endinterface
`default_nettype wire

@@ rtl/lgrs_cell.sv @@
// One grid column: holds the two previous rows' bits and computes both next states.
`timescale 1ns / 1ps
`default_nettype none
module lgrs_cell (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire lgrs_pkg::cell_ctrl_t ctrl,
    input  wire                   live,
    input  wire                   row_bit,
    input  wire                   up_l,
    input  wire                   up_r,
    input  wire                   mid_l,
    input  wire                   mid_r,
    input  wire                   row_l,
    input  wire                   row_r,
    output logic                  up_bit,
    output logic                  mid_bit,
    output logic                  row_bit_m,
    output logic                  res_a,
    output logic                  res_b
);
    import lgrs_pkg::*;

    logic       upper_reg;
    logic       middle_reg;
    logic [3:0] n_a;
    logic [3:0] n_b;

    // Stored bits are masked at use, so a width change applies to them at once.
    assign up_bit    = upper_reg & live;
    assign mid_bit   = middle_reg & live;
    assign row_bit_m = row_bit & live;

    // Result A: middle row, with the upper row above and the arriving row below.
    assign n_a = 4'(up_l) + 4'(up_bit) + 4'(up_r) + 4'(mid_l) + 4'(mid_r)
               + 4'(row_l) + 4'(row_bit_m) + 4'(row_r);
    assign res_a = live & ((n_a == 4'd3) | (mid_bit & (n_a == 4'd2)));

    // Result B: arriving row, with the middle row above and a dead row below.
    assign n_b = 4'(mid_l) + 4'(mid_bit) + 4'(mid_r) + 4'(row_l) + 4'(row_r);
    assign res_b = live & ((n_b == 4'd3) | (row_bit_m & (n_b == 4'd2)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg  <= 1'b0;
            middle_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            upper_reg  <= 1'b0;
            middle_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            upper_reg  <= mid_bit;
            middle_reg <= row_bit_m;
        end
    end

endmodule
`default_nettype wire

@@ rtl/lgrs_out_fifo.sv @@
// Small result queue that takes up to two results per cycle and gives one while rd_ready is high.
`timescale 1ns / 1ps
`default_nettype none
module lgrs_out_fifo #(
    parameter int DATA_W = 75
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire  [1:0]        wr_cnt,
    input  wire  [DATA_W-1:0] wr_data0,
    input  wire  [DATA_W-1:0] wr_data1,
    output logic              space_two,
    output logic              rd_valid,
    input  wire               rd_ready,
    output logic [DATA_W-1:0] rd_data
);
    import lgrs_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_p1;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [PTR_W:0]    count_reg;
    logic [PTR_W:0]    count_next;
    logic              pop;

    assign pop       = rd_valid & rd_ready;
    assign rd_valid  = (count_reg != '0);
    assign rd_data   = mem[rd_ptr_reg];
    assign space_two = (count_reg <= (PTR_W+1)'(DEPTH - 2));
    assign wr_ptr_p1 = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(wr_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + (PTR_W+1)'(wr_cnt) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= wr_data0;
        end
        if (wr_cnt == 2'd2)
        begin
            mem[wr_ptr_p1] <= wr_data1;
        end
    end

endmodule
`default_nettype wire

@@ rtl/life_generation_row_stepper_top.sv @@
// Top level of the B3/S23 Life row stepper: cell chain, row counter and result queue.
//
// Grid rows arrive on the rows channel, one row per transaction, bit j holding
// column j; last_row marks the final row of a frame. For each row after the first
// of a frame, the next generation of the row above is produced; a last row also
// produces its own next generation (dead row below) with frame_done set.
// Results leave on the results channel with row_number, the row's index in the
// frame, which saturates at MAX_ROWS-1.
// A result is available on the output the cycle after its row is accepted if the queue held no earlier results.
// Throughput is one row per cycle while the result queue has room, set by the column
// chain that evaluates a whole row at once; a last row of a longer frame puts two
// results in the queue, which drain at one per cycle while results.ready is high.
// rows.ready is low while the four-entry result queue has fewer than two free
// entries, so a stalled receiver back-pressures the sender after a few rows.
// grid_columns is written through cfg_wr_en / cfg_wr_data; the user must write it only while idle (not enforced).
// Reset empties the queue, clears the stored rows and the row counter, and sets
// grid_columns to 48.
`timescale 1ns / 1ps
`default_nettype none
module life_generation_row_stepper_top #(
    parameter int ROW_WIDTH = lgrs_pkg::ROW_WIDTH_DEF,
    parameter int MAX_ROWS  = lgrs_pkg::MAX_ROWS_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_wr_en,
    input  wire  [lgrs_pkg::COLS_W-1:0] cfg_wr_data,
    lgrs_row_if.sink                    rows,
    lgrs_res_if.source                  results
);
    import lgrs_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int DATA_W = ROW_WIDTH + ROWNUM_W + 1;

    logic [COLS_W-1:0]    grid_columns_reg;
    logic [CNT_W-1:0]     rows_reg;
    logic [CNT_W-1:0]     rows_next;
    logic                 accept;
    logic                 has_a;
    logic                 has_b;
    cell_ctrl_t           ctrl;
    logic [ROW_WIDTH-1:0] up_v;
    logic [ROW_WIDTH-1:0] mid_v;
    logic [ROW_WIDTH-1:0] row_v;
    logic [ROW_WIDTH-1:0] res_a_v;
    logic [ROW_WIDTH-1:0] res_b_v;
    logic [ROW_WIDTH+1:0] up_pad;
    logic [ROW_WIDTH+1:0] mid_pad;
    logic [ROW_WIDTH+1:0] row_pad;
    logic [CNT_W-1:0]     idx_a;
    logic [CNT_W-1:0]     idx_b;
    logic [DATA_W-1:0]    word_a;
    logic [DATA_W-1:0]    word_b;
    logic [DATA_W-1:0]    wr_data0;
    logic [1:0]           wr_cnt;
    logic                 space_two;
    logic [DATA_W-1:0]    rd_data;

    assign rows.ready = space_two;
    assign accept     = rows.valid & rows.ready;
    assign has_a      = accept & (rows_reg != '0);
    assign has_b      = accept & rows.last_row;

    assign ctrl.shift = accept & ~rows.last_row;
    assign ctrl.clear = accept & rows.last_row;

    // Columns outside the grid read as dead to their neighbors.
    assign up_pad  = {1'b0, up_v, 1'b0};
    assign mid_pad = {1'b0, mid_v, 1'b0};
    assign row_pad = {1'b0, row_v, 1'b0};

    for (genvar j = 0; j < ROW_WIDTH; j++)
    begin : g_col
        lgrs_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .live      (grid_columns_reg > COLS_W'(j)),
            .row_bit   (rows.row_cells[j]),
            .up_l      (up_pad[j]),
            .up_r      (up_pad[j+2]),
            .mid_l     (mid_pad[j]),
            .mid_r     (mid_pad[j+2]),
            .row_l     (row_pad[j]),
            .row_r     (row_pad[j+2]),
            .up_bit    (up_v[j]),
            .mid_bit   (mid_v[j]),
            .row_bit_m (row_v[j]),
            .res_a     (res_a_v[j]),
            .res_b     (res_b_v[j])
        );
    end

    // The counter never exceeds MAX_ROWS, so only the last row's index needs a clamp.
    assign idx_a = rows_reg - CNT_W'(1);
    assign idx_b = (rows_reg >= CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS - 1) : rows_reg;

    assign word_a   = {res_a_v, ROWNUM_W'(idx_a), 1'b0};
    assign word_b   = {res_b_v, ROWNUM_W'(idx_b), 1'b1};
    assign wr_data0 = has_a ? word_a : word_b;
    assign wr_cnt   = 2'(has_a) + 2'(has_b);

    always_comb
    begin
        rows_next = rows_reg;
        if (accept)
        begin
            if (rows.last_row)
            begin
                rows_next = '0;
            end
            else if (rows_reg < CNT_W'(MAX_ROWS))
            begin
                rows_next = rows_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg <= GRID_COLUMNS_RST;
            rows_reg         <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                grid_columns_reg <= cfg_wr_data;
            end
            rows_reg <= rows_next;
        end
    end

    lgrs_out_fifo #(
        .DATA_W (DATA_W)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_cnt    (wr_cnt),
        .wr_data0  (wr_data0),
        .wr_data1  (word_b),
        .space_two (space_two),
        .rd_valid  (results.valid),
        .rd_ready  (results.ready),
        .rd_data   (rd_data)
    );

    assign results.next_row_cells = rd_data[DATA_W-1 -: ROW_WIDTH];
    assign results.row_number     = rd_data[ROWNUM_W:1];
    assign results.frame_done     = rd_data[0];

endmodule
`default_nettype wire

@@ test/life_generation_row_stepper_top_test.sv @@
// Self-checking testbench for the B3/S23 Life row stepper, with a scoreboard class.
`timescale 1ns / 1ps
module life_generation_row_stepper_top_test;
    import lgrs_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int TOTAL_ROWS  = 1750;
    localparam int LONG_FRAME  = MAX_ROWS_DEF + 6;

    typedef struct packed {
        logic [ROW_WIDTH_DEF-1:0] cells;
        logic [ROWNUM_W-1:0]      row_idx;
        logic                     done;
    } gen_row_t;

    // Keeps a private copy of the stepper state and the queue of rows it should emit.
    class generation_scoreboard;
        bit [COLS_W-1:0]        columns;
        bit [ROW_WIDTH_DEF-1:0] upper_cells;
        bit [ROW_WIDTH_DEF-1:0] middle_cells;
        int unsigned            rows_held;
        gen_row_t               expected_rows[$];
        int unsigned            mismatches;
        int unsigned            checked;
        int unsigned            rows_in;
        int unsigned            frames;

        function new();
            columns      = GRID_COLUMNS_RST;
            upper_cells  = '0;
            middle_cells = '0;
            rows_held    = 0;
            mismatches   = 0;
            checked      = 0;
            rows_in      = 0;
            frames       = 0;
        endfunction

        function bit [ROW_WIDTH_DEF-1:0] column_mask();
            int unsigned w;
            w = columns;
            if (w > ROW_WIDTH_DEF)
                w = ROW_WIDTH_DEF;
            if (w == 0)
                return '0;
            if (w >= 64)
                return '1;
            return (64'd1 << w) - 64'd1;
        endfunction

        // Pads each row with a dead column on both sides so every cell sees eight neighbors.
        function bit [ROW_WIDTH_DEF-1:0] evolve_row(bit [ROW_WIDTH_DEF-1:0] above,
                                                   bit [ROW_WIDTH_DEF-1:0] here,
                                                   bit [ROW_WIDTH_DEF-1:0] below,
                                                   bit [ROW_WIDTH_DEF-1:0] mask);
            bit [ROW_WIDTH_DEF+1:0] a;
            bit [ROW_WIDTH_DEF+1:0] h;
            bit [ROW_WIDTH_DEF+1:0] b;
            bit [ROW_WIDTH_DEF-1:0] nxt;
            int                     n;
            a = {1'b0, above & mask, 1'b0};
            h = {1'b0, here & mask, 1'b0};
            b = {1'b0, below & mask, 1'b0};
            for (int c = 0; c < ROW_WIDTH_DEF; c++)
            begin
                n = a[c] + a[c+1] + a[c+2] + h[c] + h[c+2] + b[c] + b[c+1] + b[c+2];
                nxt[c] = (n == 3) || (h[c+1] && n == 2);
            end
            return nxt & mask;
        endfunction

        function bit [ROWNUM_W-1:0] clamp_row_index(int unsigned idx);
            if (idx > MAX_ROWS_DEF - 1)
                idx = MAX_ROWS_DEF - 1;
            return idx[ROWNUM_W-1:0];
        endfunction

        function void row_accepted(bit [ROW_WIDTH_DEF-1:0] cells, bit last);
            bit [ROW_WIDTH_DEF-1:0] mask;
            bit [ROW_WIDTH_DEF-1:0] row;
            gen_row_t               e;
            mask = column_mask();
            row  = cells & mask;
            rows_in++;
            if (rows_held >= 1)
            begin
                e.cells   = evolve_row(upper_cells, middle_cells, row, mask);
                e.row_idx = clamp_row_index(rows_held - 1);
                e.done    = 1'b0;
                expected_rows.push_back(e);
            end
            if (last)
            begin
                e.cells   = evolve_row((rows_held >= 1) ? middle_cells : '0, row, '0, mask);
                e.row_idx = clamp_row_index(rows_held);
                e.done    = 1'b1;
                expected_rows.push_back(e);
                frames++;
                upper_cells  = '0;
                middle_cells = '0;
                rows_held    = 0;
            end
            else
            begin
                upper_cells  = middle_cells & mask;
                middle_cells = row;
                if (rows_held < MAX_ROWS_DEF)
                    rows_held++;
            end
        endfunction

        function void result_accepted(logic [ROW_WIDTH_DEF-1:0] cells,
                                      logic [ROWNUM_W-1:0] row_idx, logic done);
            gen_row_t e;
            checked++;
            if (expected_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result row: cells %h row %0d frame_done %b",
                             cells, row_idx, done);
                return;
            end
            e = expected_rows.pop_front();
            if (e.cells !== cells || e.row_idx !== row_idx || e.done !== done)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result mismatch: expected cells %h row %0d frame_done %b,",
                             e.cells, e.row_idx, e.done);
                    $display("                 got cells %h row %0d frame_done %b",
                             cells, row_idx, done);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_rows.size();
        endfunction
    endclass

    bit                clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [COLS_W-1:0] cfg_wr_data;

    lgrs_row_if rows_ch ();
    lgrs_res_if results_ch ();

    life_generation_row_stepper_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rows        (rows_ch),
        .results     (results_ch)
    );

    generation_scoreboard gen_sb = new();

    bit          sender_gaps;
    bit          receiver_gaps;
    bit          hold_request;
    int unsigned idle_cycles;
    int unsigned items_sent;

    always #4 clk = ~clk;

    // Any cycle with no transaction on either channel counts toward the hang limit.
    always @(posedge clk)
    begin
        if (rows_ch.valid && rows_ch.ready || results_ch.valid && results_ch.ready)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no transaction for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic bit [ROW_WIDTH_DEF-1:0] random_row();
        bit [ROW_WIDTH_DEF-1:0] a;
        bit [ROW_WIDTH_DEF-1:0] b;
        bit [ROW_WIDTH_DEF-1:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return a;
            1: return a & b;
            2: return a & b & c;
            3: return a | b;
            4: return '0;
            5: return '1;
            6: return 64'd7 << $urandom_range(0, 61);
            default: return (a & b) | (64'd1 << $urandom_range(0, 63));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_row(input bit [ROW_WIDTH_DEF-1:0] cells, input bit last);
        int unsigned gap;
        gap = sender_gaps ? $urandom_range(0, 18) : 0;
        if (gap != 0)
        begin
            rows_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rows_ch.valid     <= 1'b1;
        rows_ch.row_cells <= cells;
        rows_ch.last_row  <= last;
        do
            @(posedge clk);
        while (!rows_ch.ready);
        gen_sb.row_accepted(cells, last);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input int unsigned len, input bit close);
        for (int unsigned i = 0; i < len; i++)
            send_row(random_row(), close && (i == len - 1));
    endtask

    task automatic wait_drained();
        rows_ch.valid <= 1'b0;
        @(negedge clk);
        while (gen_sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_columns(input bit [COLS_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en      <= 1'b0;
        gen_sb.columns = value;
    endtask

    initial
    begin : receiver
        int unsigned stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = receiver_gaps ? $urandom_range(0, 18) : 0;
            if (hold_request)
            begin
                stall        = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (stall != 0)
            begin
                results_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            results_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!results_ch.valid);
            gen_sb.result_accepted(results_ch.next_row_cells, results_ch.row_number,
                                   results_ch.frame_done);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        bit [COLS_W-1:0] width_plan[];
        int unsigned     phase;
        int unsigned     phase_end;
        int unsigned     len;
        int unsigned     fails;
        bit              leave_open;

        width_plan         = '{64, 1, 0, 127, 33, 2, 65, 63, 17, 8, 100, 48};
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        rows_ch.valid      = 1'b0;
        rows_ch.row_cells  = '0;
        rows_ch.last_row   = 1'b0;
        results_ch.ready   = 1'b0;
        sender_gaps        = 1'b1;
        receiver_gaps      = 1'b1;
        hold_request       = 1'b0;
        idle_cycles        = 0;
        items_sent         = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset width of 48: bits above column 47 must be ignored.
        send_row('1, 1'b1);
        send_row(64'h0, 1'b0);
        send_row(64'h0000_0000_0000_001C, 1'b0);
        send_row(64'h0, 1'b0);
        send_row(64'h0, 1'b1);
        send_row(64'hFFFF_0000_0000_0003, 1'b0);
        send_row(64'h8001_C000_0000_C000, 1'b1);

        // Full width exercises both edge columns.
        write_columns(7'd64);
        send_row('1, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row('1, 1'b1);

        // Width shrinks in the middle of a frame.
        send_row(64'hC000_0000_0000_0007, 1'b0);
        send_row(64'h8000_0000_0000_00E1, 1'b0);
        write_columns(7'd8);
        send_row(64'hFFFF_FFFF_FFFF_FF3C, 1'b0);
        send_row(64'h0000_0000_0000_0181, 1'b1);

        write_columns(7'd0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);

        write_columns(7'd127);
        send_row('1, 1'b1);
        send_row(random_row(), 1'b0);
        send_row(random_row(), 1'b1);

        write_columns(7'd1);
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);

        phase = 0;
        while (items_sent < TOTAL_ROWS)
        begin
            write_columns((phase < width_plan.size()) ? width_plan[phase]
                                                      : $urandom_range(0, 127));
            sender_gaps   = ($urandom_range(0, 2) != 0);
            receiver_gaps = ($urandom_range(0, 2) != 0);
            if (phase == 3)
            begin
                // One frame long enough to saturate the row counter.
                sender_gaps = 1'b0;
                send_frame(LONG_FRAME, 1'b1);
            end
            else
            begin
                if (phase == 6)
                begin
                    hold_request = 1'b1;
                    sender_gaps  = 1'b0;
                end
                phase_end = items_sent + $urandom_range(40, 80);
                while (items_sent < phase_end)
                begin
                    case ($urandom_range(0, 9))
                        0: len = 1;
                        1: len = $urandom_range(20, 60);
                        default: len = $urandom_range(2, 10);
                    endcase
                    leave_open = (items_sent + len >= phase_end) && ($urandom_range(0, 2) == 0);
                    send_frame(len, !leave_open);
                end
            end
            phase++;
        end

        rows_ch.valid <= 1'b0;
        while (gen_sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        fails = gen_sb.mismatches + gen_sb.pending();
        $display("Stepped %0d rows in %0d closed frames and checked %0d result rows.",
                 gen_sb.rows_in, gen_sb.frames, gen_sb.checked);
        $display("Widths 0 to 127, mid-frame width changes, a %0d-row frame%s",
                 LONG_FRAME, " and a stalled receiver.");
        if (fails == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("%0d failures", fails);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/lgrs_pkg.sv
rtl/lgrs_ifs.sv
rtl/lgrs_cell.sv
rtl/lgrs_out_fifo.sv
rtl/life_generation_row_stepper_top.sv
test/life_generation_row_stepper_top_test.sv
